FILE: design/sdos_pkg.sv
// sdos_pkg: shared constants and types of the four-sensor steering block
// used by every file under design; depends on nothing
`default_nettype none

package sdos_pkg;

	localparam int NUM_CH      = 4;
	localparam int CH_W        = 2;
	localparam int SAMPLE_W    = 12;
	localparam int SUM_W       = 15;
	localparam int COUNT_W     = 3;
	localparam int LEVEL_W     = 7;
	localparam int ERR_W       = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int SAMPLES     = 5;
	localparam int GAIN        = 50;
	localparam int LEVEL_SCALE = 100;
	localparam int STEER_SCALE = LEVEL_SCALE * GAIN;
	localparam int CAL_MAX_RST = 4000;

	// mean by reciprocal multiply, exact for any sum of SUM_W bits
	localparam int MEAN_SHIFT  = 18;
	localparam int MEAN_RECIP  = ((1 << MEAN_SHIFT) + SAMPLES - 1) / SAMPLES;
	localparam int MEAN_PROD_W = SUM_W + MEAN_SHIFT + 1;

	// shared divider operand widths
	localparam int DIVIDEND_W  = 22;
	localparam int DIVISOR_W   = 16;
	localparam int DIV_CNT_W   = 5;

	localparam int ERR_POS_LIM = 63;
	localparam int ERR_NEG_LIM = 64;

	typedef struct packed {
		logic [NUM_CH-1:0][SAMPLE_W-1:0] lo;
		logic [NUM_CH-1:0][SAMPLE_W-1:0] hi;
	} sdos_cal_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} sdos_div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} sdos_div_rsp_t;

endpackage

`default_nettype wire

FILE: design/sdos_if.sv
// sdos_in_if and sdos_out_if: valid/ready channels of the steering block
// depends on sdos_pkg for field widths
`default_nettype none

interface sdos_in_if;
	logic                          valid;
	logic                          ready;
	logic [sdos_pkg::CH_W-1:0]     channel;
	logic [sdos_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, channel, sample, input ready);
	modport sink(input valid, channel, sample, output ready);
endinterface

interface sdos_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [sdos_pkg::ERR_W-1:0]   steer_error;
	logic        [sdos_pkg::LEVEL_W-1:0] left_x_level;
	logic        [sdos_pkg::LEVEL_W-1:0] left_y_level;
	logic        [sdos_pkg::LEVEL_W-1:0] right_x_level;
	logic        [sdos_pkg::LEVEL_W-1:0] right_y_level;

	modport source(output valid, steer_error, left_x_level, left_y_level,
		right_x_level, right_y_level, input ready);
	modport sink(input valid, steer_error, left_x_level, left_y_level,
		right_x_level, right_y_level, output ready);
endinterface

`default_nettype wire

FILE: design/sdos_cal.sv
// sdos_cal: calibration register file, min and max reading per channel
// depends on sdos_pkg
`default_nettype none

module sdos_cal (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sdos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sdos_pkg::SAMPLE_W-1:0]  cfg_wdata,
	output sdos_pkg::sdos_cal_t                 cal
);

	sdos_pkg::sdos_cal_t cal_q;

	// index bit 0 picks max over min, upper bits pick the channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sdos_pkg::NUM_CH; i++) begin
				cal_q.lo[i] <= '0;
				cal_q.hi[i] <= sdos_pkg::SAMPLE_W'(sdos_pkg::CAL_MAX_RST);
			end
		end else if (cfg_we) begin
			if (cfg_index[0])
				cal_q.hi[cfg_index[sdos_pkg::CFG_IDX_W-1:1]] <= cfg_wdata;
			else
				cal_q.lo[cfg_index[sdos_pkg::CFG_IDX_W-1:1]] <= cfg_wdata;
		end
	end

	assign cal = cal_q;

endmodule

`default_nettype wire

FILE: design/sdos_div.sv
// sdos_div: shared restoring divider, one quotient bit per cycle
// depends on sdos_pkg for operand widths and request/response structs
`default_nettype none

module sdos_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sdos_pkg::sdos_div_req_t req,
	output sdos_pkg::sdos_div_rsp_t      rsp
);

	localparam int DW = sdos_pkg::DIVIDEND_W;
	localparam int VW = sdos_pkg::DIVISOR_W;

	logic                              busy_q;
	logic                              done_q;
	logic [sdos_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [DW-1:0]                     quo_q;
	logic [VW-1:0]                     rem_q;
	logic [VW-1:0]                     divisor_q;
	logic [VW:0]                       trial;
	logic                              fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sdos_pkg::DIV_CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, divisor_q}) : trial[VW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

FILE: design/sensor_diff_over_sum_steering.sv
// sensor_diff_over_sum_steering: four-sensor difference-over-sum steering block
// depends on sdos_pkg, sdos_if, sdos_cal and sdos_div
//
// smp carries requests of one 12-bit sample tagged with a channel 0..3. Each
// channel averages five samples; once all four channels hold a fresh mean the
// block normalises them to levels 0..100 against the calibration registers and
// sends one request on res: the signed steering error and the four levels.
// Calibration is written through cfg_we / cfg_index / cfg_wdata, index 2c for
// the minimum and 2c+1 for the maximum of channel c; the user must write it
// only while the block is idle, which the block itself does not enforce. When
// idle the block can take a new sample right after the last, even one that
// completes a mean. A sample that makes all four means fresh starts four level
// divisions and one error division on the shared divider; res is valid after
// them, once the output register is free. A channel with an empty calibration
// range skips its division. smp.ready is low during that work. The result sits
// in an output register: a stalled receiver holds the block only when a second
// result is finished before the first is taken. Reset clears sums, counts, means
// and fresh marks, sets calibration to 0..4000 and empties the output register.
`default_nettype none

module sensor_diff_over_sum_steering (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sdos_in_if.sink                             smp,
	sdos_out_if.source                          res,
	input  wire logic                           cfg_we,
	input  wire logic [sdos_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sdos_pkg::SAMPLE_W-1:0]  cfg_wdata
);

	localparam int NC = sdos_pkg::NUM_CH;
	localparam int SW = sdos_pkg::SAMPLE_W;
	localparam int LW = sdos_pkg::LEVEL_W;
	localparam int DW = sdos_pkg::DIVIDEND_W;
	localparam int VW = sdos_pkg::DIVISOR_W;
	localparam int PW = sdos_pkg::MEAN_PROD_W;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_LVL_GO   = 6'b000010,
		ST_LVL_WAIT = 6'b000100,
		ST_ERR_GO   = 6'b001000,
		ST_ERR_WAIT = 6'b010000,
		ST_EMIT     = 6'b100000
	} sdos_state_t;

	sdos_state_t                           state_q;
	logic [NC-1:0][sdos_pkg::SUM_W-1:0]    sum_q;
	logic [NC-1:0][sdos_pkg::COUNT_W-1:0]  cnt_q;
	logic [NC-1:0][SW-1:0]                 mean_q;
	logic [NC-1:0]                         fresh_q;
	logic [NC-1:0][LW-1:0]                 level_q;
	logic [sdos_pkg::CH_W-1:0]             idx_q;
	logic signed [sdos_pkg::ERR_W-1:0]     err_q;

	logic                                  res_valid_q;
	logic signed [sdos_pkg::ERR_W-1:0]     res_err_q;
	logic [NC-1:0][LW-1:0]                 res_level_q;

	sdos_pkg::sdos_cal_t                   cal;
	sdos_pkg::sdos_div_req_t               div_req;
	sdos_pkg::sdos_div_rsp_t               div_rsp;

	logic                                  accept;
	logic [sdos_pkg::SUM_W-1:0]            sum_nx;
	logic [sdos_pkg::COUNT_W-1:0]          cnt_nx;
	logic                                  mean_done;
	logic [PW-1:0]                         mean_prod;
	logic [SW-1:0]                         mean_nx;
	logic [NC-1:0]                         fresh_set;
	logic [SW-1:0]                         lo;
	logic [SW-1:0]                         hi;
	logic [SW-1:0]                         m_clamp;
	logic                                  cal_ok;
	logic [LW:0]                           left;
	logic [LW:0]                           right;
	logic [LW:0]                           mag;
	logic [LW-1:0]                         q_sat;
	logic                                  out_free;

	sdos_cal u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cal       (cal)
	);

	sdos_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign smp.ready = (state_q == ST_IDLE);
	assign accept    = smp.valid && smp.ready;
	assign sum_nx    = sum_q[smp.channel] + sdos_pkg::SUM_W'(smp.sample);
	assign cnt_nx    = cnt_q[smp.channel] + 1'b1;
	assign mean_done = cnt_nx >= sdos_pkg::COUNT_W'(sdos_pkg::SAMPLES);
	assign out_free  = !res_valid_q || res.ready;

	// mean of the completed sum by reciprocal multiply
	assign mean_prod = PW'(sum_nx) * PW'(sdos_pkg::MEAN_RECIP);
	assign mean_nx   = mean_prod[sdos_pkg::MEAN_SHIFT +: SW];

	always_comb begin
		fresh_set               = fresh_q;
		fresh_set[smp.channel]  = 1'b1;
	end

	// clamp of the current channel's mean into its calibration window
	assign lo     = cal.lo[idx_q];
	assign hi     = cal.hi[idx_q];
	assign cal_ok = hi > lo;
	always_comb begin
		if (mean_q[idx_q] < lo)
			m_clamp = lo;
		else if (mean_q[idx_q] > hi)
			m_clamp = hi;
		else
			m_clamp = mean_q[idx_q];
	end

	assign left  = {1'b0, level_q[0]} + {1'b0, level_q[1]};
	assign right = {1'b0, level_q[3]} + {1'b0, level_q[2]};
	assign mag   = (left >= right) ? (left - right) : (right - left);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		if (state_q == ST_LVL_GO) begin
			div_req.start    = cal_ok;
			div_req.dividend = DW'(m_clamp - lo) * DW'(sdos_pkg::LEVEL_SCALE);
			div_req.divisor  = VW'(hi - lo);
		end else if (state_q == ST_ERR_GO) begin
			div_req.start    = 1'b1;
			div_req.dividend = DW'(mag) * DW'(sdos_pkg::STEER_SCALE);
			div_req.divisor  = VW'(VW'(left + right) * VW'(sdos_pkg::LEVEL_SCALE) + 1'b1);
		end
	end

	assign q_sat = (div_rsp.quotient > DW'(sdos_pkg::ERR_NEG_LIM)) ?
		LW'(sdos_pkg::ERR_NEG_LIM) : div_rsp.quotient[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			mean_q  <= '0;
			fresh_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mean_done) begin
							sum_q[smp.channel]  <= '0;
							cnt_q[smp.channel]  <= '0;
							mean_q[smp.channel] <= mean_nx;
							if (&fresh_set) begin
								fresh_q <= '0;
								idx_q   <= '0;
								state_q <= ST_LVL_GO;
							end else begin
								fresh_q <= fresh_set;
							end
						end else begin
							sum_q[smp.channel] <= sum_nx;
							cnt_q[smp.channel] <= cnt_nx;
						end
					end
				end
				ST_LVL_GO: begin
					if (cal_ok) begin
						state_q <= ST_LVL_WAIT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == sdos_pkg::CH_W'(NC - 1)) ? ST_ERR_GO : ST_LVL_GO;
					end
				end
				ST_LVL_WAIT: begin
					if (div_rsp.done) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == sdos_pkg::CH_W'(NC - 1)) ? ST_ERR_GO : ST_LVL_GO;
					end
				end
				ST_ERR_GO: begin
					state_q <= ST_ERR_WAIT;
				end
				ST_ERR_WAIT: begin
					if (div_rsp.done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// level and error payload
	always_ff @(posedge clk) begin
		if (state_q == ST_LVL_GO && !cal_ok)
			level_q[idx_q] <= '0;
		else if (state_q == ST_LVL_WAIT && div_rsp.done)
			level_q[idx_q] <= div_rsp.quotient[LW-1:0];
		if (state_q == ST_ERR_WAIT && div_rsp.done) begin
			if (left >= right)
				err_q <= (q_sat > LW'(sdos_pkg::ERR_POS_LIM)) ?
					sdos_pkg::ERR_W'(sdos_pkg::ERR_POS_LIM) : q_sat;
			else
				err_q <= -$signed(q_sat);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && out_free)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			res_err_q   <= err_q;
			res_level_q <= level_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.steer_error   = res_err_q;
	assign res.left_x_level  = res_level_q[0];
	assign res.left_y_level  = res_level_q[1];
	assign res.right_x_level = res_level_q[3];
	assign res.right_y_level = res_level_q[2];

endmodule

`default_nettype wire

FILE: tb/sensor_diff_over_sum_steering_tb.sv
// sensor_diff_over_sum_steering_tb: self-checking bench of the four-sensor steering block
// feeds sample requests with random idling and checks every result against a local predictor
// depends on sdos_pkg, sdos_if and sensor_diff_over_sum_steering
`timescale 1ns / 100ps

module sensor_diff_over_sum_steering_tb;
	import sdos_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 300;
	localparam int LONG_HOLD     = 4000;
	localparam int RANDOM_ITEMS  = 460;
	localparam int PHASE_ITEMS   = 64;
	localparam int MAX_REPORTS   = 10;
	localparam int FRAME_LEN     = NUM_CH * SAMPLES;
	localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CAL_CH0_MIN, CAL_CH0_MAX, CAL_CH1_MIN, CAL_CH1_MAX,
		CAL_CH2_MIN, CAL_CH2_MAX, CAL_CH3_MIN, CAL_CH3_MAX
	} cal_reg_e;

	typedef struct packed {
		logic [CH_W-1:0]     channel;
		logic [SAMPLE_W-1:0] sample;
	} sample_req_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] steer_error;
		logic [LEVEL_W-1:0]      left_x_level;
		logic [LEVEL_W-1:0]      left_y_level;
		logic [LEVEL_W-1:0]      right_x_level;
		logic [LEVEL_W-1:0]      right_y_level;
	} steer_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SAMPLE_W-1:0]  cfg_wdata;

	sdos_in_if  smp ();
	sdos_out_if res ();

	sensor_diff_over_sum_steering dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (smp),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [SAMPLE_W-1:0] cal_lo   [NUM_CH];
	logic [SAMPLE_W-1:0] cal_hi   [NUM_CH];
	logic [SUM_W-1:0]    ch_sum   [NUM_CH];
	logic [COUNT_W-1:0]  ch_count [NUM_CH];
	logic [SAMPLE_W-1:0] ch_mean  [NUM_CH];
	logic [NUM_CH-1:0]   ch_fresh;

	sample_req_t sample_queue [$];
	steer_res_t  steer_expected [$];
	sample_req_t next_req;
	steer_res_t  next_res;

	int idle_pct;
	int send_gap;
	int stall_left;
	int hold_token;
	int hold_seen;
	int mismatches;
	int items_queued;
	int phase_items;
	int phase;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	function automatic cal_reg_e cal_reg(int c, bit is_max);
		case (c)
			0: return is_max ? CAL_CH0_MAX : CAL_CH0_MIN;
			1: return is_max ? CAL_CH1_MAX : CAL_CH1_MIN;
			2: return is_max ? CAL_CH2_MAX : CAL_CH2_MIN;
			default: return is_max ? CAL_CH3_MAX : CAL_CH3_MIN;
		endcase
	endfunction

	function automatic int unsigned level_of_ch(int c);
		int unsigned lo, hi, m;
		lo = cal_lo[c];
		hi = cal_hi[c];
		m = ch_mean[c];
		if (hi <= lo)
			return 0;
		if (m < lo)
			m = lo;
		if (m > hi)
			m = hi;
		return ((m - lo) * LEVEL_SCALE) / (hi - lo);
	endfunction

	// accumulate one sample; returns 1 when all four means are fresh
	function automatic bit steer_predict(input logic [CH_W-1:0] ch,
		input logic [SAMPLE_W-1:0] val, output steer_res_t r);
		int unsigned lx, ly, rx, ry, left, right, mag, q;
		int err;
		r = '0;
		ch_sum[ch] = ch_sum[ch] + val;
		ch_count[ch] = ch_count[ch] + 1'b1;
		if (ch_count[ch] >= SAMPLES) begin
			ch_mean[ch] = SAMPLE_W'(ch_sum[ch] / SAMPLES);
			ch_sum[ch] = '0;
			ch_count[ch] = '0;
			ch_fresh[ch] = 1'b1;
		end
		if (!(&ch_fresh))
			return 1'b0;
		ch_fresh = '0;
		lx = level_of_ch(0);
		ly = level_of_ch(1);
		ry = level_of_ch(2);
		rx = level_of_ch(3);
		left = lx + ly;
		right = rx + ry;
		mag = (left >= right) ? left - right : right - left;
		q = (mag * STEER_SCALE) / ((left + right) * LEVEL_SCALE + 1);
		if (q > ERR_NEG_LIM)
			q = ERR_NEG_LIM;
		err = (left >= right) ? int'(q) : -int'(q);
		if (err > ERR_POS_LIM)
			err = ERR_POS_LIM;
		r.steer_error = ERR_W'(err);
		r.left_x_level = LEVEL_W'(lx);
		r.left_y_level = LEVEL_W'(ly);
		r.right_x_level = LEVEL_W'(rx);
		r.right_y_level = LEVEL_W'(ry);
		return 1'b1;
	endfunction

	task automatic check_result();
		steer_res_t want, got;
		got.steer_error = res.steer_error;
		got.left_x_level = res.left_x_level;
		got.left_y_level = res.left_y_level;
		got.right_x_level = res.right_x_level;
		got.right_y_level = res.right_y_level;
		if (steer_expected.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("unexpected result at %0t: err %0d levels %0d %0d %0d %0d", $realtime,
					got.steer_error, got.left_x_level, got.left_y_level,
					got.right_x_level, got.right_y_level);
		end else begin
			want = steer_expected.pop_front();
			if (got.steer_error !== want.steer_error || got.left_x_level !== want.left_x_level ||
				got.left_y_level !== want.left_y_level ||
				got.right_x_level !== want.right_x_level ||
				got.right_y_level !== want.right_y_level) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch at %0t: err %0d/%0d lx %0d/%0d ly %0d/%0d rx %0d/%0d ry %0d/%0d",
						$realtime, want.steer_error, got.steer_error,
						want.left_x_level, got.left_x_level, want.left_y_level, got.left_y_level,
						want.right_x_level, got.right_x_level,
						want.right_y_level, got.right_y_level);
			end
		end
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.channel <= '0;
			smp.sample <= '0;
			send_gap = 0;
		end else begin
			if (smp.valid && smp.ready) begin
				if (steer_predict(smp.channel, smp.sample, next_res))
					steer_expected.push_back(next_res);
			end
			if (!smp.valid || smp.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					smp.valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					next_req = sample_queue.pop_front();
					smp.valid <= 1'b1;
					smp.channel <= next_req.channel;
					smp.sample <= next_req.sample;
					if ($urandom_range(0, 99) < idle_pct)
						send_gap = pick_gap();
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
			hold_seen = 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = pick_gap();
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic push_sample(int c, int v);
		sample_req_t req;
		req.channel = CH_W'(c);
		req.sample = SAMPLE_W'(v);
		sample_queue.push_back(req);
		items_queued++;
		phase_items++;
	endtask

	function automatic int near_value(int v);
		int x;
		x = v + int'($urandom_range(0, 40)) - 20;
		if (x < 0)
			x = 0;
		if (x > SAMPLE_TOP)
			x = SAMPLE_TOP;
		return x;
	endfunction

	function automatic int pick_target(int c);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, SAMPLE_TOP);
			1: return cal_lo[c];
			2: return cal_hi[c];
			3: return 0;
			4: return SAMPLE_TOP;
			default: return (int'(cal_lo[c]) + int'(cal_hi[c])) / 2;
		endcase
	endfunction

	// five samples per channel in shuffled order, optionally cut short
	task automatic push_frame(int len);
		int order [FRAME_LEN];
		int target [NUM_CH];
		int k, j, t;
		for (k = 0; k < FRAME_LEN; k++)
			order[k] = k % NUM_CH;
		for (k = FRAME_LEN - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		for (k = 0; k < NUM_CH; k++)
			target[k] = pick_target(k);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				push_sample(order[k], $urandom_range(0, SAMPLE_TOP));
			else
				push_sample(order[k], near_value(target[order[k]]));
		end
	endtask

	task automatic add_random_chunk();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			push_frame(FRAME_LEN);
		else if (r < 90)
			push_frame($urandom_range(1, FRAME_LEN - 1));
		else
			repeat ($urandom_range(1, 4))
				push_sample($urandom_range(0, NUM_CH - 1), $urandom_range(0, SAMPLE_TOP));
	endtask

	task automatic write_reg(cal_reg_e r, logic [SAMPLE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic apply_phase_cal(int p);
		logic [SAMPLE_W-1:0] lo [NUM_CH];
		logic [SAMPLE_W-1:0] hi [NUM_CH];
		int c;
		for (c = 0; c < NUM_CH; c++) begin
			case (p)
				1: begin
					lo[c] = '0;
					hi[c] = SAMPLE_W'(SAMPLE_TOP);
				end
				2: begin
					// degenerate ranges: equal, inverted, empty and one step wide
					case (c)
						0: begin
							lo[c] = SAMPLE_W'(SAMPLE_TOP);
							hi[c] = SAMPLE_W'(SAMPLE_TOP);
						end
						1: begin
							lo[c] = SAMPLE_W'(SAMPLE_TOP);
							hi[c] = '0;
						end
						2: begin
							lo[c] = '0;
							hi[c] = '0;
						end
						default: begin
							lo[c] = '0;
							hi[c] = SAMPLE_W'(1);
						end
					endcase
				end
				3: begin
					lo[c] = SAMPLE_W'($urandom_range(0, SAMPLE_TOP - 1));
					hi[c] = lo[c] + 1'b1;
				end
				6: begin
					lo[c] = '0;
					hi[c] = SAMPLE_W'(CAL_MAX_RST);
				end
				default: begin
					lo[c] = SAMPLE_W'($urandom_range(0, 2000));
					hi[c] = SAMPLE_W'($urandom_range(2000, SAMPLE_TOP));
					if ($urandom_range(0, 9) == 0) begin
						lo[c] = SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
						hi[c] = SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
					end
				end
			endcase
		end
		for (c = 0; c < NUM_CH; c++) begin
			write_reg(cal_reg(c, 1'b0), lo[c]);
			write_reg(cal_reg(c, 1'b1), hi[c]);
			cal_lo[c] = lo[c];
			cal_hi[c] = hi[c];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sample_queue.size() != 0 || smp.valid || steer_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int c, k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CAL_CH0_MIN;
		cfg_wdata = '0;
		smp.valid = 1'b0;
		smp.channel = '0;
		smp.sample = '0;
		res.ready = 1'b0;
		idle_pct = 0;
		hold_token = 0;
		mismatches = 0;
		items_queued = 0;
		cycles = 0;
		ch_fresh = '0;
		for (c = 0; c < NUM_CH; c++) begin
			cal_lo[c] = '0;
			cal_hi[c] = SAMPLE_W'(CAL_MAX_RST);
			ch_sum[c] = '0;
			ch_count[c] = '0;
			ch_mean[c] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale left pair against empty right pair, left means above calibration
		for (k = 0; k < FRAME_LEN; k++)
			push_sample(k % NUM_CH, (k % NUM_CH < 2) ? SAMPLE_TOP : 0);
		wait_idle();

		phase = 0;
		while (phase < 7 || items_queued < RANDOM_ITEMS + FRAME_LEN) begin
			if (phase != 0)
				apply_phase_cal(phase);
			idle_pct = (phase == 1) ? 0 : 25;
			if (phase == 5)
				hold_token++;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				add_random_chunk();
			wait_idle();
			phase++;
		end

		if (mismatches == 0 && steer_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sensor_diff_over_sum_steering.f
design/sdos_pkg.sv
design/sdos_if.sv
design/sdos_cal.sv
design/sdos_div.sv
design/sensor_diff_over_sum_steering.sv
tb/sensor_diff_over_sum_steering_tb.sv
